// ===== rtl/qbpm_pkg.sv =====
package qbpm_pkg;

  // register indexes, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_SRC_X_SPAN = 3'd0,
    REG_SRC_Y_SPAN = 3'd1,
    REG_CORNER0    = 3'd2,
    REG_CORNER1    = 3'd3,
    REG_CORNER2    = 3'd4,
    REG_CORNER3    = 3'd5,
    REG_LOADED     = 3'd6
  } reg_idx_t;

  // largest magnitude of a wide intermediate
  localparam logic signed [63:0] WIDE_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  // quotient bits resolved by the divider below the saturation point
  localparam int QBITS = 62;

  function automatic logic signed [63:0] clamp65(input logic signed [64:0] s);
    logic signed [64:0] lim;
    lim = {1'b0, WIDE_LIM};
    if (s > lim) begin
      return WIDE_LIM;
    end else if (s < -lim) begin
      return -WIDE_LIM;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return clamp65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return clamp65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

endpackage

// ===== rtl/qbpm_ifs.sv =====
interface qbpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;

  modport source (output valid, src_x, src_y, input ready);
  modport sink (input valid, src_x, src_y, output ready);
endinterface

interface qbpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] echo_x;
  logic signed [31:0] echo_y;
  logic signed [31:0] dest_first;
  logic signed [31:0] dest_second;
  logic               map_error;

  modport source (output valid, echo_x, echo_y, dest_first, dest_second, map_error,
                  input ready);
  modport sink (input valid, echo_x, echo_y, dest_first, dest_second, map_error,
                output ready);
endinterface

// ===== rtl/qbpm_mul.sv =====
module qbpm_mul #(
  parameter int LANES     = 1,
  parameter int PW        = 1,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [LANES-1:0][63:0]  in_a,
  input  logic [LANES-1:0][63:0]  in_b,
  input  logic [PW-1:0]           in_pay,
  output logic                    out_valid,
  output logic [LANES-1:0][63:0]  out_p,
  output logic [PW-1:0]           out_pay
);
  import qbpm_pkg::*;

  localparam int DEPTH = 5;

  logic [DEPTH-1:0]              vld;
  logic [PW-1:0]                 pay [DEPTH];
  logic [LANES-1:0][63:0]        ua, ub;
  logic [LANES-1:0]              ng1, ng2, ng3, ng4;
  logic [LANES-1:0][63:0]        p00, p01, p10, p11;
  logic [LANES-1:0][63:0]        p00c, p11c;
  logic [LANES-1:0][64:0]        crs;
  logic [LANES-1:0][127:0]       full;
  logic [LANES-1:0][127:0]       sh;
  logic [LANES-1:0][63:0]        rsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= in_pay;
      for (int k = 1; k < DEPTH; k++) begin
        pay[k] <= pay[k-1];
      end
    end
  end

  // truncate toward zero on the magnitude, saturate
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sh[l] = full[l] >> FRAC_BITS;
      if (sh[l] > {64'd0, WIDE_LIM}) begin
        rsat[l] = WIDE_LIM;
      end else begin
        rsat[l] = sh[l][63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        ua[l]   <= mag(in_a[l]);
        ub[l]   <= mag(in_b[l]);
        ng1[l]  <= in_a[l][63] ^ in_b[l][63];
        // 32x32 partial products
        p00[l]  <= ua[l][31:0] * ub[l][31:0];
        p01[l]  <= ua[l][31:0] * ub[l][63:32];
        p10[l]  <= ua[l][63:32] * ub[l][31:0];
        p11[l]  <= ua[l][63:32] * ub[l][63:32];
        ng2[l]  <= ng1[l];
        crs[l]  <= {1'b0, p01[l]} + {1'b0, p10[l]};
        p00c[l] <= p00[l];
        p11c[l] <= p11[l];
        ng3[l]  <= ng2[l];
        full[l] <= {p11c[l], p00c[l]} + {31'd0, crs[l], 32'd0};
        ng4[l]  <= ng3[l];
        out_p[l] <= ng4[l] ? (64'd0 - rsat[l]) : rsat[l];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_pay   = pay[DEPTH-1];

endmodule

// ===== rtl/qbpm_div.sv =====
module qbpm_div #(
  parameter int LANES     = 1,
  parameter int PW        = 1,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [LANES-1:0][63:0]  in_a,
  input  logic [LANES-1:0][63:0]  in_b,
  input  logic [PW-1:0]           in_pay,
  output logic                    out_valid,
  output logic [LANES-1:0][63:0]  out_q,
  output logic [PW-1:0]           out_pay
);
  import qbpm_pkg::*;

  localparam int DEPTH = QBITS + 3;

  logic [DEPTH-1:0]              vld;
  logic [PW-1:0]                 pay [DEPTH];
  logic [LANES-1:0][63:0]        ua0, ub0, nsh;
  logic [LANES-1:0]              ng0;

  // one quotient bit per stage
  logic [LANES-1:0][63:0]        rem  [QBITS+1];
  logic [LANES-1:0][63:0]        dvs  [QBITS+1];
  logic [LANES-1:0][QBITS-1:0]   nb   [QBITS+1];
  logic [LANES-1:0][QBITS-1:0]   qb   [QBITS+1];
  logic [LANES-1:0]              ovf  [QBITS+1];
  logic [LANES-1:0]              ng   [QBITS+1];

  logic [LANES-1:0][64:0]        trial [1:QBITS];
  logic [LANES-1:0]              ge    [1:QBITS];
  logic [LANES-1:0][64:0]        nrem  [1:QBITS];
  logic [LANES-1:0][63:0]        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= in_pay;
      for (int k = 1; k < DEPTH; k++) begin
        pay[k] <= pay[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nsh[l] = ua0[l] << FRAC_BITS;
      res[l] = ovf[QBITS][l] ? WIDE_LIM : {2'b00, qb[QBITS][l]};
    end
    for (int k = 1; k <= QBITS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[k][l] = {rem[k-1][l], nb[k-1][l][QBITS-1]};
        ge[k][l]    = trial[k][l] >= {1'b0, dvs[k-1][l]};
        nrem[k][l]  = ge[k][l] ? (trial[k][l] - {1'b0, dvs[k-1][l]}) : trial[k][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        ua0[l] <= mag(in_a[l]);
        ub0[l] <= mag(in_b[l]);
        ng0[l] <= in_a[l][63] ^ in_b[l][63];
        // quotient at or above the limit shows in the top numerator bits
        ovf[0][l] <= (ua0[l] >> (QBITS - FRAC_BITS)) >= ub0[l];
        rem[0][l] <= ua0[l] >> (QBITS - FRAC_BITS);
        dvs[0][l] <= ub0[l];
        nb[0][l]  <= nsh[l][QBITS-1:0];
        qb[0][l]  <= '0;
        ng[0][l]  <= ng0[l];
        out_q[l]  <= ng[QBITS][l] ? (64'd0 - res[l]) : res[l];
      end
      for (int k = 1; k <= QBITS; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= nrem[k][l][63:0];
          dvs[k][l] <= dvs[k-1][l];
          nb[k][l]  <= {nb[k-1][l][QBITS-2:0], 1'b0};
          qb[k][l]  <= {qb[k-1][l][QBITS-2:0], ge[k][l]};
          ovf[k][l] <= ovf[k-1][l];
          ng[k][l]  <= ng[k-1][l];
        end
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_pay   = pay[DEPTH-1];

endmodule

// ===== rtl/quad_bilinear_point_mapper_unit.sv =====
// channel   dir   handshake      payload
// in_ch     in    valid/ready    src_x, src_y
// out_ch    out   valid/ready    echo_x, echo_y, dest_first, dest_second, map_error
// apb       in    psel/penable   7 registers at 8*i, 64-bit data, pready tied high
//
// one item per cycle while the output buffer is not full; the pipe runs through three 65-stage
// dividers (one quotient bit a stage) and three 5-stage multipliers in series
// synchronous reset clears the registers, the stage valids and the output side
// the whole pipe holds on one enable; a 2-entry output buffer takes one more
// item after the consumer stalls, then ready drops until it drains
module quad_bilinear_point_mapper_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  qbpm_in_if.sink      in_ch,
  qbpm_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import qbpm_pkg::*;

  // payload carried alongside each arithmetic unit
  typedef struct packed {
    logic [31:0] echo_x;
    logic [31:0] echo_y;
  } pay1_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] v;
  } pay2_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] v;
    logic signed [63:0] xl0, yl0, xl1, yl1, xl2, yl2, xl3, yl3;
  } pts_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] v;
    logic signed [63:0] xl0, xl3, yl0, yl3;
    logic signed [63:0] n13;
    logic signed [63:0] first_ab;
    logic               case_a;
    logic               case_b;
  } pay3_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] dm;
    logic signed [63:0] xl3, yl0, yl3;
    logic signed [63:0] m13;
    logic signed [63:0] first_ab;
    logic               case_a;
    logic               case_b;
  } pay4_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] dm;
    logic signed [63:0] xl3, yl0, yl3;
    logic signed [63:0] m13;
    logic signed [63:0] first_ab;
    logic signed [63:0] sec_b;
    logic signed [63:0] acc;
    logic signed [63:0] p2;
    logic               case_a;
    logic               case_b;
  } num_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] xl3, yl3;
    logic signed [63:0] m13;
    logic signed [63:0] first_ab;
    logic signed [63:0] sec_b;
    logic               case_a;
    logic               case_b;
    logic               dm_zero;
  } pay5_t;

  typedef struct packed {
    logic [31:0]        echo_x;
    logic [31:0]        echo_y;
    logic signed [63:0] first;
    logic signed [63:0] yl3;
    logic signed [63:0] first_ab;
    logic signed [63:0] sec_b;
    logic               case_a;
    logic               case_b;
    logic               dm_zero;
  } pay6_t;

  typedef struct packed {
    logic [31:0] echo_x;
    logic [31:0] echo_y;
    logic [31:0] dest_first;
    logic [31:0] dest_second;
    logic        map_error;
  } res_t;

  localparam logic signed [63:0] COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] COORD_LO = -COORD_HI - 64'sd1;

  // coordinate: low COORD_WIDTH bits of a 32-bit slot, sign-extended
  function automatic logic signed [63:0] sext(input logic [31:0] raw);
    return {{(64 - COORD_WIDTH){raw[COORD_WIDTH-1]}}, raw[COORD_WIDTH-1:0]};
  endfunction

  function automatic logic [31:0] out_coord(input logic signed [63:0] x);
    logic signed [63:0] c;
    c = x;
    if (c > COORD_HI) begin
      c = COORD_HI;
    end else if (c < COORD_LO) begin
      c = COORD_LO;
    end
    return c[31:0];
  endfunction

  // ---------------------------------------------------------------- registers
  logic [63:0] src_x_span, src_y_span;
  logic [63:0] corner_dest [4];
  logic        corners_loaded;
  reg_idx_t    widx, ridx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[5:3]);
  assign ridx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_x_span     <= '0;
      src_y_span     <= '0;
      corner_dest[0] <= '0;
      corner_dest[1] <= '0;
      corner_dest[2] <= '0;
      corner_dest[3] <= '0;
      corners_loaded <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_SRC_X_SPAN: src_x_span     <= pwdata;
        REG_SRC_Y_SPAN: src_y_span     <= pwdata;
        REG_CORNER0:    corner_dest[0] <= pwdata;
        REG_CORNER1:    corner_dest[1] <= pwdata;
        REG_CORNER2:    corner_dest[2] <= pwdata;
        REG_CORNER3:    corner_dest[3] <= pwdata;
        REG_LOADED:     corners_loaded <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SRC_X_SPAN: prdata = src_x_span;
      REG_SRC_Y_SPAN: prdata = src_y_span;
      REG_CORNER0:    prdata = corner_dest[0];
      REG_CORNER1:    prdata = corner_dest[1];
      REG_CORNER2:    prdata = corner_dest[2];
      REG_CORNER3:    prdata = corner_dest[3];
      REG_LOADED:     prdata = {63'd0, corners_loaded};
      default:        prdata = '0;
    endcase
  end

  // registers must only change while idle (the user's duty, not enforced here), so every stage reads them directly
  logic signed [63:0] x0, x1, y0, y3;
  logic signed [63:0] z [4];
  logic signed [63:0] w [4];
  logic               err_cfg;

  always_comb begin
    x0 = sext(src_x_span[31:0]);
    x1 = sext(src_x_span[63:32]);
    y0 = sext(src_y_span[31:0]);
    y3 = sext(src_y_span[63:32]);
    for (int k = 0; k < 4; k++) begin
      z[k] = sext(corner_dest[k][31:0]);
      w[k] = sext(corner_dest[k][63:32]);
    end
    err_cfg = !corners_loaded || (x1 == x0) || (y0 == y3);
  end

  // ---------------------------------------------------------------- flow control
  logic en;
  logic o_valid, sk_valid;
  res_t o_data, sk_data, fin;

  assign en          = !sk_valid;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------- u and v
  logic [1:0][63:0] d1_a, d1_b, d1_q;
  logic             d1_valid;
  pay1_t            d1_in_pay, d1_pay;

  always_comb begin
    d1_a[0] = sext(in_ch.src_x) - x0;
    d1_b[0] = x1 - x0;
    d1_a[1] = y0 - sext(in_ch.src_y);
    d1_b[1] = y0 - y3;
    d1_in_pay.echo_x = in_ch.src_x;
    d1_in_pay.echo_y = in_ch.src_y;
  end

  qbpm_div #(.LANES(2), .PW($bits(pay1_t)), .FRAC_BITS(FRAC_BITS)) u_div_uv (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_ch.valid),
    .in_a(d1_a), .in_b(d1_b), .in_pay(d1_in_pay),
    .out_valid(d1_valid), .out_q(d1_q), .out_pay(d1_pay)
  );

  // ---------------------------------------------------------------- edge points
  // lanes: xL0 yL0 by u on 0-1, xL1 yL1 by v on 1-2, xL2 yL2 by u on 3-2,
  // xL3 yL3 by v on 0-3
  logic [7:0][63:0] m1_a, m1_b, m1_p;
  logic             m1_valid;
  pay2_t            m1_in_pay, m1_pay;

  always_comb begin
    m1_a[0] = d1_q[0];  m1_b[0] = sat_sub(z[1], z[0]);
    m1_a[1] = d1_q[0];  m1_b[1] = sat_sub(w[1], w[0]);
    m1_a[2] = d1_q[1];  m1_b[2] = sat_sub(z[2], z[1]);
    m1_a[3] = d1_q[1];  m1_b[3] = sat_sub(w[2], w[1]);
    m1_a[4] = d1_q[0];  m1_b[4] = sat_sub(z[2], z[3]);
    m1_a[5] = d1_q[0];  m1_b[5] = sat_sub(w[2], w[3]);
    m1_a[6] = d1_q[1];  m1_b[6] = sat_sub(z[3], z[0]);
    m1_a[7] = d1_q[1];  m1_b[7] = sat_sub(w[3], w[0]);
    m1_in_pay.echo_x = d1_pay.echo_x;
    m1_in_pay.echo_y = d1_pay.echo_y;
    m1_in_pay.v      = d1_q[1];
  end

  qbpm_mul #(.LANES(8), .PW($bits(pay2_t)), .FRAC_BITS(FRAC_BITS)) u_mul_lerp (
    .clk(clk), .rst(rst), .en(en), .in_valid(d1_valid),
    .in_a(m1_a), .in_b(m1_b), .in_pay(m1_in_pay),
    .out_valid(m1_valid), .out_p(m1_p), .out_pay(m1_pay)
  );

  logic pt_valid;
  pts_t pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (en) begin
      pt_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt.echo_x <= m1_pay.echo_x;
      pt.echo_y <= m1_pay.echo_y;
      pt.v      <= m1_pay.v;
      pt.xl0    <= sat_add(z[0], m1_p[0]);
      pt.yl0    <= sat_add(w[0], m1_p[1]);
      pt.xl1    <= sat_add(z[1], m1_p[2]);
      pt.yl1    <= sat_add(w[1], m1_p[3]);
      pt.xl2    <= sat_add(z[3], m1_p[4]);
      pt.yl2    <= sat_add(w[3], m1_p[5]);
      pt.xl3    <= sat_add(z[0], m1_p[6]);
      pt.yl3    <= sat_add(w[0], m1_p[7]);
    end
  end

  // ---------------------------------------------------------------- slope set-up
  logic               sd_valid;
  pay3_t              sd;
  logic signed [63:0] sd_d13, sd_n02, sd_d02;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (en) begin
      sd_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd.echo_x   <= pt.echo_x;
      sd.echo_y   <= pt.echo_y;
      sd.v        <= pt.v;
      sd.xl0      <= pt.xl0;
      sd.xl3      <= pt.xl3;
      sd.yl0      <= pt.yl0;
      sd.yl3      <= pt.yl3;
      sd.n13      <= sat_sub(pt.yl1, pt.yl3);
      // vertical L3-L1 wins over vertical L0-L2
      sd.case_a   <= pt.xl1 == pt.xl3;
      sd.case_b   <= pt.xl2 == pt.xl0;
      sd.first_ab <= (pt.xl1 == pt.xl3) ? pt.xl1 : pt.xl2;
      sd_d13      <= sat_sub(pt.xl1, pt.xl3);
      sd_n02      <= sat_sub(pt.yl2, pt.yl0);
      sd_d02      <= sat_sub(pt.xl2, pt.xl0);
    end
  end

  // ---------------------------------------------------------------- slopes
  logic [1:0][63:0] d2_a, d2_b, d2_q;
  logic             d2_valid;
  pay3_t            d2_pay;

  always_comb begin
    d2_a[0] = sd.n13;  d2_b[0] = sd_d13;
    d2_a[1] = sd_n02;  d2_b[1] = sd_d02;
  end

  qbpm_div #(.LANES(2), .PW($bits(pay3_t)), .FRAC_BITS(FRAC_BITS)) u_div_slope (
    .clk(clk), .rst(rst), .en(en), .in_valid(sd_valid),
    .in_a(d2_a), .in_b(d2_b), .in_pay(sd),
    .out_valid(d2_valid), .out_q(d2_q), .out_pay(d2_pay)
  );

  // ---------------------------------------------------------------- slope products
  // lanes: m13*xL3, m02*xL0, and v*(yL1-yL3) for the vertical L0-L2 case
  logic [2:0][63:0] m2_a, m2_b, m2_p;
  logic             m2_valid;
  pay4_t            m2_in_pay, m2_pay;

  always_comb begin
    m2_a[0] = d2_q[0];    m2_b[0] = d2_pay.xl3;
    m2_a[1] = d2_q[1];    m2_b[1] = d2_pay.xl0;
    m2_a[2] = d2_pay.v;   m2_b[2] = d2_pay.n13;
    m2_in_pay.echo_x   = d2_pay.echo_x;
    m2_in_pay.echo_y   = d2_pay.echo_y;
    m2_in_pay.dm       = sat_sub(d2_q[0], d2_q[1]);
    m2_in_pay.xl3      = d2_pay.xl3;
    m2_in_pay.yl0      = d2_pay.yl0;
    m2_in_pay.yl3      = d2_pay.yl3;
    m2_in_pay.m13      = d2_q[0];
    m2_in_pay.first_ab = d2_pay.first_ab;
    m2_in_pay.case_a   = d2_pay.case_a;
    m2_in_pay.case_b   = d2_pay.case_b;
  end

  qbpm_mul #(.LANES(3), .PW($bits(pay4_t)), .FRAC_BITS(FRAC_BITS)) u_mul_slope (
    .clk(clk), .rst(rst), .en(en), .in_valid(d2_valid),
    .in_a(m2_a), .in_b(m2_b), .in_pay(m2_in_pay),
    .out_valid(m2_valid), .out_p(m2_p), .out_pay(m2_pay)
  );

  // ---------------------------------------------------------------- numerator
  // m13*xL3 - yL3 - m02*xL0 + yL0, one saturating add a stage
  logic [2:0] nm_valid;
  num_t       nm1, nm2, nm3;
  num_t       nm2_next, nm3_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= '0;
    end else if (en) begin
      nm_valid <= {nm_valid[1:0], m2_valid};
    end
  end

  always_comb begin
    nm2_next     = nm1;
    nm2_next.acc = sat_sub(nm1.acc, nm1.p2);
    nm3_next     = nm2;
    nm3_next.acc = sat_add(nm2.acc, nm2.yl0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm1.echo_x   <= m2_pay.echo_x;
      nm1.echo_y   <= m2_pay.echo_y;
      nm1.dm       <= m2_pay.dm;
      nm1.xl3      <= m2_pay.xl3;
      nm1.yl0      <= m2_pay.yl0;
      nm1.yl3      <= m2_pay.yl3;
      nm1.m13      <= m2_pay.m13;
      nm1.first_ab <= m2_pay.first_ab;
      nm1.case_a   <= m2_pay.case_a;
      nm1.case_b   <= m2_pay.case_b;
      nm1.sec_b    <= sat_add(m2_pay.yl3, m2_p[2]);
      nm1.acc      <= sat_sub(m2_p[0], m2_pay.yl3);
      nm1.p2       <= m2_p[1];

      nm2          <= nm2_next;
      nm3          <= nm3_next;
    end
  end

  // ---------------------------------------------------------------- intersection x
  logic [0:0][63:0] d3_a, d3_b, d3_q;
  logic             d3_valid;
  pay5_t            d3_in_pay, d3_pay;

  always_comb begin
    d3_a[0] = nm3.acc;
    d3_b[0] = nm3.dm;
    d3_in_pay.echo_x   = nm3.echo_x;
    d3_in_pay.echo_y   = nm3.echo_y;
    d3_in_pay.xl3      = nm3.xl3;
    d3_in_pay.yl3      = nm3.yl3;
    d3_in_pay.m13      = nm3.m13;
    d3_in_pay.first_ab = nm3.first_ab;
    d3_in_pay.sec_b    = nm3.sec_b;
    d3_in_pay.case_a   = nm3.case_a;
    d3_in_pay.case_b   = nm3.case_b;
    d3_in_pay.dm_zero  = nm3.dm == 64'sd0;
  end

  qbpm_div #(.LANES(1), .PW($bits(pay5_t)), .FRAC_BITS(FRAC_BITS)) u_div_cross (
    .clk(clk), .rst(rst), .en(en), .in_valid(nm_valid[2]),
    .in_a(d3_a), .in_b(d3_b), .in_pay(d3_in_pay),
    .out_valid(d3_valid), .out_q(d3_q), .out_pay(d3_pay)
  );

  // ---------------------------------------------------------------- intersection y
  logic               fx_valid;
  pay6_t              fx;
  logic signed [63:0] fx_m13, fx_fd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fx_valid <= 1'b0;
    end else if (en) begin
      fx_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx.echo_x   <= d3_pay.echo_x;
      fx.echo_y   <= d3_pay.echo_y;
      fx.first    <= d3_q[0];
      fx.yl3      <= d3_pay.yl3;
      fx.first_ab <= d3_pay.first_ab;
      fx.sec_b    <= d3_pay.sec_b;
      fx.case_a   <= d3_pay.case_a;
      fx.case_b   <= d3_pay.case_b;
      fx.dm_zero  <= d3_pay.dm_zero;
      fx_m13      <= d3_pay.m13;
      fx_fd       <= sat_sub(d3_q[0], d3_pay.xl3);
    end
  end

  logic [0:0][63:0] m3_a, m3_b, m3_p;
  logic             m3_valid;
  pay6_t            m3_pay;

  assign m3_a[0] = fx_m13;
  assign m3_b[0] = fx_fd;

  qbpm_mul #(.LANES(1), .PW($bits(pay6_t)), .FRAC_BITS(FRAC_BITS)) u_mul_cross (
    .clk(clk), .rst(rst), .en(en), .in_valid(fx_valid),
    .in_a(m3_a), .in_b(m3_b), .in_pay(fx),
    .out_valid(m3_valid), .out_p(m3_p), .out_pay(m3_pay)
  );

  // ---------------------------------------------------------------- result select
  logic signed [63:0] fsel, ssel;
  logic               ferr;

  always_comb begin
    ferr = err_cfg || (!m3_pay.case_a && !m3_pay.case_b && m3_pay.dm_zero);
    if (m3_pay.case_a) begin
      fsel = m3_pay.first_ab;
      ssel = m3_pay.yl3;
    end else if (m3_pay.case_b) begin
      fsel = m3_pay.first_ab;
      ssel = m3_pay.sec_b;
    end else begin
      fsel = m3_pay.first;
      ssel = sat_add(m3_p[0], m3_pay.yl3);
    end
    fin.echo_x = m3_pay.echo_x;
    fin.echo_y = m3_pay.echo_y;
    if (ferr) begin
      fin.dest_first  = '0;
      fin.dest_second = '0;
      fin.map_error   = 1'b1;
    end else begin
      fin.dest_first  = out_coord(fsel);
      fin.dest_second = out_coord(ssel);
      fin.map_error   = 1'b0;
    end
  end

  // ---------------------------------------------------------------- output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (out_ch.ready || !o_valid) begin
      if (sk_valid) begin
        o_valid  <= 1'b1;
        sk_valid <= 1'b0;
      end else begin
        o_valid  <= m3_valid;
      end
    end else if (en && m3_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !o_valid) begin
      o_data <= sk_valid ? sk_data : fin;
    end else if (en) begin
      sk_data <= fin;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.echo_x      = o_data.echo_x;
  assign out_ch.echo_y      = o_data.echo_y;
  assign out_ch.dest_first  = o_data.dest_first;
  assign out_ch.dest_second = o_data.dest_second;
  assign out_ch.map_error   = o_data.map_error;

endmodule
